FILE: rtl/core/grc_pkg.sv
`default_nettype none
package grc_pkg;

	// screen, texture and grid geometry
	localparam int SCREEN_W = 512;
	localparam int SCREEN_H = 512;
	localparam int TEX_SIZE = 64;
	localparam int MAP_DIM  = 32;

	localparam int ONE_Q16   = 65536;
	localparam int PERP_MAX  = 4194303;
	localparam int TEX_MAX   = 4194304;
	localparam int PERP_W    = 22;
	localparam int TEX_W     = $clog2(TEX_SIZE);
	localparam int MAP_IW    = $clog2(MAP_DIM);
	localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int CELL_W    = 4;

	// configuration port
	localparam int POS_W = 21;
	localparam int VEC_W = 18;
	localparam int CFG_W = 21;
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_POS_X   = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_POS_Y   = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_DIR_X   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DIR_Y   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_PLANE_X = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_PLANE_Y = 3'd5;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;

	// shared divider
	localparam int LH_NUM = SCREEN_H * ONE_Q16;
	localparam int LH_W   = $clog2(LH_NUM + 1);
	localparam int TS_NUM = TEX_SIZE * ONE_Q16;
	localparam int TS_CNT = $clog2(TS_NUM + 1);
	localparam int DVD_W  = 40;
	localparam int DVS_W  = (LH_W > PERP_W) ? LH_W : PERP_W;
	localparam int DIV_CW = $clog2(DVD_W + 1);

	// shared multiplier
	localparam int MUL_AW = 25;
	localparam int MUL_BW = 35;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	typedef struct packed {
		logic                  req_type;
		logic [8:0]            column;
		logic [4:0]            cell_x;
		logic [4:0]            cell_y;
		logic [CELL_W-1:0]     cell_value;
	} req_t;

	typedef struct packed {
		logic [8:0]            out_column;
		logic [4:0]            hit_x;
		logic [4:0]            hit_y;
		logic                  side;
		logic [PERP_W-1:0]     perp_dist;
		logic [8:0]            draw_start;
		logic [8:0]            draw_end;
		logic [3:0]            tex_num;
		logic [5:0]            tex_x;
		logic [22:0]           tex_step;
		logic [22:0]           tex_pos_start;
	} desc_t;

	typedef struct packed {
		logic                  start;
		logic [DVD_W-1:0]      dividend;
		logic [DVS_W-1:0]      divisor;
		logic [DIV_CW-1:0]     count;
	} div_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/grc_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module grc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire grc_pkg::div_cmd_t             cmd,
	output logic                               done,
	output logic [grc_pkg::DVD_W-1:0]          quotient
);
	logic [grc_pkg::DVD_W-1:0]  dvd_q;
	logic [grc_pkg::DVD_W-1:0]  quo_q;
	logic [grc_pkg::DVS_W-1:0]  dvs_q;
	logic [grc_pkg::DVS_W-1:0]  rem_q;
	logic [grc_pkg::DVS_W-1:0]  rem_nx;
	logic [grc_pkg::DVS_W:0]    rem_ext;
	logic                       ge;
	logic [grc_pkg::DIV_CW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	always_comb begin
		rem_ext = {rem_q, dvd_q[grc_pkg::DVD_W-1]};
		ge      = rem_ext >= {1'b0, dvs_q};
		rem_nx  = ge ? grc_pkg::DVS_W'(rem_ext - {1'b0, dvs_q})
		             : grc_pkg::DVS_W'(rem_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == grc_pkg::DIV_CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			// left-align the dividend so only count bits are walked
			dvd_q <= cmd.dividend << (grc_pkg::DIV_CW'(grc_pkg::DVD_W) - cmd.count);
			dvs_q <= cmd.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[grc_pkg::DVD_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[grc_pkg::DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: rtl/core/grc_mul.sv
`default_nettype none
// signed multiplier, registered product
module grc_mul (
	input  wire logic                                clk,
	input  wire logic signed [grc_pkg::MUL_AW-1:0]   a,
	input  wire logic signed [grc_pkg::MUL_BW-1:0]   b,
	output logic signed [grc_pkg::MUL_PW-1:0]        p
);
	logic signed [grc_pkg::MUL_PW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= grc_pkg::MUL_PW'(a) * grc_pkg::MUL_PW'(b);
	end

	assign p = p_q;
endmodule
`default_nettype wire

FILE: rtl/core/grc_map.sv
`default_nettype none
// grid cell store, cleared by a sweep after reset
module grc_map (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          we,
	input  wire logic [grc_pkg::MAP_AW-1:0]    waddr,
	input  wire logic [grc_pkg::CELL_W-1:0]    wdata,
	input  wire logic [grc_pkg::MAP_AW-1:0]    raddr,
	output logic [grc_pkg::CELL_W-1:0]         rdata,
	output logic                               busy
);
	logic [grc_pkg::CELL_W-1:0] mem [grc_pkg::MAP_DEPTH];
	logic [grc_pkg::MAP_AW:0]   clr_q;
	logic [grc_pkg::CELL_W-1:0] rdata_q;
	logic                       clearing;

	assign clearing = !clr_q[grc_pkg::MAP_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[grc_pkg::MAP_AW-1:0]] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
	assign busy  = clearing;
endmodule
`default_nettype wire

FILE: rtl/core/grid_ray_wall_caster.sv
`default_nettype none
// channel  | direction | handshake             | payload
// req      | in        | req_valid / req_stall | grc_pkg::req_t  (cell write or column cast)
// desc     | out       | desc_valid/desc_stall | grc_pkg::desc_t (one wall descriptor per cast)
// cfg      | in        | cfg_we                | cfg_index, cfg_data (camera registers)
//
// a cell write is taken while idle; a cast sets up the ray, then walks the grid (a WALK and
// a WALKRD state per cell stepped through the registered map read port, WALK alone for a
// step off the grid); the serial divider sets most of the cast, and the delta and distance
// divisions are skipped when their ray component is zero, the texture step when lh is zero
// after reset the map is swept to zero with req_stall held high
// one request is worked at a time; req_stall stays high until the descriptor is taken
// a stalled descriptor holds in its output register
module grid_ray_wall_caster (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire grc_pkg::req_t                 req,
	output logic                               desc_valid,
	input  wire logic                          desc_stall,
	output grc_pkg::desc_t                     desc,
	input  wire logic                          cfg_we,
	input  wire logic [grc_pkg::CFG_IW-1:0]    cfg_index,
	input  wire logic [grc_pkg::CFG_W-1:0]     cfg_data
);
	localparam int RAY_W = 20;
	localparam int SD_W  = 42;
	localparam int DD_W  = 33;

	typedef enum logic [4:0] {
		S_IDLE, S_RAYX, S_RAYY, S_RAYW,
		S_DIVX, S_DIVXW, S_MULX, S_MULXW,
		S_DIVY, S_DIVYW, S_MULY, S_MULYW,
		S_WALK, S_WALKRD, S_PERP, S_PERPW,
		S_LH, S_LHW, S_TS, S_TSW,
		S_TPOS, S_TPOSW, S_WMUL, S_WALL,
		S_OUT
	} state_t;

	state_t state_q;

	// camera registers
	logic [grc_pkg::POS_W-1:0]        pos_x_q, pos_y_q;
	logic signed [grc_pkg::VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	// per-cast working registers
	logic signed [17:0]               cam_q;
	logic signed [RAY_W-1:0]          rdx_q, rdy_q;
	logic [DD_W-1:0]                  ddx_q, ddy_q;
	logic [SD_W-1:0]                  sdx_q, sdy_q;
	logic                             xinf_q, yinf_q;
	logic signed [6:0]                mx_q, my_q;
	logic                             side_q;
	logic [grc_pkg::PERP_W-1:0]       perp_q;
	logic [grc_pkg::LH_W-1:0]         lh_q;
	grc_pkg::desc_t                   desc_q;

	// shared units
	grc_pkg::div_cmd_t                div_cmd;
	logic                             div_done;
	logic [grc_pkg::DVD_W-1:0]        div_quo;
	logic signed [grc_pkg::MUL_AW-1:0] mul_a;
	logic signed [grc_pkg::MUL_BW-1:0] mul_b;
	logic signed [grc_pkg::MUL_PW-1:0] mul_p;

	// map port
	logic                             map_we;
	logic [grc_pkg::MAP_AW-1:0]       map_waddr;
	logic [grc_pkg::MAP_AW-1:0]       map_raddr;
	logic [grc_pkg::CELL_W-1:0]       map_rdata;
	logic                             map_busy;

	logic                             req_acc;
	logic [26:0]                      cam_u;
	logic signed [17:0]               cam_n;
	logic                             stx_neg, sty_neg;
	logic [16:0]                      frac_x, frac_y;
	logic [RAY_W-2:0]                 mag_rx, mag_ry;
	logic                             xstep;
	logic signed [6:0]                nmx, nmy;
	logic                             n_out;
	logic signed [6:0]                edge_c;
	logic signed [23:0]               num;
	logic [21:0]                      num_mag;
	logic signed [RAY_W-1:0]          r_hit;
	logic [RAY_W-2:0]                 r_mag;
	logic [grc_pkg::LH_W-2:0]         lh2;
	logic [grc_pkg::LH_W-2:0]         k_n;
	logic [grc_pkg::LH_W:0]           de_sum;
	logic [8:0]                       ds_n, de_n;
	logic [15:0]                      wfrac;
	logic [grc_pkg::TEX_W-1:0]        texx_n;
	logic                             mirror;

	assign req_stall  = (state_q != S_IDLE) || map_busy;
	assign req_acc    = req_valid && !req_stall;
	assign desc_valid = (state_q == S_OUT);
	assign desc       = desc_q;

	// camera x in Q16, from -1 to just under 1
	assign cam_u = 27'((27'(req.column) << 17) / grc_pkg::SCREEN_W);
	assign cam_n = signed'(18'(cam_u) - 18'(grc_pkg::ONE_Q16));

	// axis setup
	assign stx_neg = rdx_q < 0;
	assign sty_neg = rdy_q < 0;
	assign frac_x  = stx_neg ? {1'b0, pos_x_q[15:0]}
	                         : 17'(grc_pkg::ONE_Q16) - {1'b0, pos_x_q[15:0]};
	assign frac_y  = sty_neg ? {1'b0, pos_y_q[15:0]}
	                         : 17'(grc_pkg::ONE_Q16) - {1'b0, pos_y_q[15:0]};
	assign mag_rx  = (RAY_W-1)'(stx_neg ? -rdx_q : rdx_q);
	assign mag_ry  = (RAY_W-1)'(sty_neg ? -rdy_q : rdy_q);

	// one walk step: x only when its side distance is strictly smaller, ties go to y
	assign xstep = !xinf_q && (yinf_q || (sdx_q < sdy_q));
	assign nmx   = xstep ? (stx_neg ? mx_q - 7'sd1 : mx_q + 7'sd1) : mx_q;
	assign nmy   = xstep ? my_q : (sty_neg ? my_q - 7'sd1 : my_q + 7'sd1);
	assign n_out = (nmx < 0) || (nmy < 0) || (nmx >= grc_pkg::MAP_DIM)
	            || (nmy >= grc_pkg::MAP_DIM);
	assign map_raddr = grc_pkg::MAP_AW'(int'(nmx[grc_pkg::MAP_IW-1:0]) * grc_pkg::MAP_DIM
	                 + int'(nmy[grc_pkg::MAP_IW-1:0]));

	// map write from a write request; cells outside the grid are dropped
	assign map_we    = req_acc && (req.req_type == grc_pkg::REQ_WRITE)
	                && (int'(req.cell_x) < grc_pkg::MAP_DIM)
	                && (int'(req.cell_y) < grc_pkg::MAP_DIM);
	assign map_waddr = grc_pkg::MAP_AW'(int'(req.cell_x) * grc_pkg::MAP_DIM
	                 + int'(req.cell_y));

	// distance from camera to the crossed cell edge
	assign edge_c  = side_q ? (my_q + (sty_neg ? 7'sd1 : 7'sd0))
	                        : (mx_q + (stx_neg ? 7'sd1 : 7'sd0));
	assign num     = $signed({2'b0, edge_c[5:0], 16'h0})
	               - $signed({3'b0, side_q ? pos_y_q : pos_x_q});
	assign num_mag = 22'(num < 0 ? -num : num);
	assign r_hit   = side_q ? rdy_q : rdx_q;
	assign r_mag   = side_q ? mag_ry : mag_rx;

	// draw span and first texture row offset
	assign lh2    = lh_q[grc_pkg::LH_W-1:1];
	assign ds_n   = (int'(lh2) >= grc_pkg::SCREEN_H / 2) ? 9'd0
	              : 9'(grc_pkg::SCREEN_H / 2 - int'(lh2));
	assign de_sum = (grc_pkg::LH_W+1)'(lh2) + (grc_pkg::LH_W+1)'(grc_pkg::SCREEN_H / 2);
	assign de_n   = (int'(de_sum) >= grc_pkg::SCREEN_H) ? 9'(grc_pkg::SCREEN_H - 1)
	              : 9'(de_sum);
	assign k_n    = (int'(lh2) > grc_pkg::SCREEN_H / 2)
	              ? (grc_pkg::LH_W-1)'(int'(lh2) - grc_pkg::SCREEN_H / 2) : '0;

	// texture column from the fraction of the wall hit point
	assign wfrac  = (side_q ? pos_x_q[15:0] : pos_y_q[15:0]) + mul_p[31:16];
	assign texx_n = grc_pkg::TEX_W'((32'(wfrac) * grc_pkg::TEX_SIZE) >> 16);
	assign mirror = (!side_q && rdx_q > 0) || (side_q && rdy_q < 0);

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_RAYX: begin
				mul_a = grc_pkg::MUL_AW'(plane_x_q);
				mul_b = grc_pkg::MUL_BW'(cam_q);
			end
			S_RAYY: begin
				mul_a = grc_pkg::MUL_AW'(plane_y_q);
				mul_b = grc_pkg::MUL_BW'(cam_q);
			end
			S_MULX: begin
				mul_a = grc_pkg::MUL_AW'(signed'({1'b0, frac_x}));
				mul_b = grc_pkg::MUL_BW'(signed'({1'b0, ddx_q}));
			end
			S_MULY: begin
				mul_a = grc_pkg::MUL_AW'(signed'({1'b0, frac_y}));
				mul_b = grc_pkg::MUL_BW'(signed'({1'b0, ddy_q}));
			end
			S_TPOS: begin
				mul_a = grc_pkg::MUL_AW'(signed'({1'b0, k_n}));
				mul_b = grc_pkg::MUL_BW'(signed'({1'b0, desc_q.tex_step}));
			end
			S_WMUL: begin
				mul_a = grc_pkg::MUL_AW'(signed'({1'b0, perp_q}));
				mul_b = grc_pkg::MUL_BW'(side_q ? rdx_q : rdy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared divider commands
	always_comb begin
		div_cmd = '0;
		case (state_q)
			S_DIVX: begin
				div_cmd.start    = (rdx_q != 0);
				div_cmd.dividend = grc_pkg::DVD_W'(1) << 32;
				div_cmd.divisor  = grc_pkg::DVS_W'(mag_rx);
				div_cmd.count    = grc_pkg::DIV_CW'(DD_W);
			end
			S_DIVY: begin
				div_cmd.start    = (rdy_q != 0);
				div_cmd.dividend = grc_pkg::DVD_W'(1) << 32;
				div_cmd.divisor  = grc_pkg::DVS_W'(mag_ry);
				div_cmd.count    = grc_pkg::DIV_CW'(DD_W);
			end
			S_PERP: begin
				div_cmd.start    = (r_hit != 0);
				div_cmd.dividend = grc_pkg::DVD_W'({num_mag, 16'h0});
				div_cmd.divisor  = grc_pkg::DVS_W'(r_mag);
				div_cmd.count    = grc_pkg::DIV_CW'(38);
			end
			S_LH: begin
				div_cmd.start    = 1'b1;
				div_cmd.dividend = grc_pkg::DVD_W'(grc_pkg::LH_NUM);
				div_cmd.divisor  = (perp_q == '0) ? grc_pkg::DVS_W'(1)
				                                  : grc_pkg::DVS_W'(perp_q);
				div_cmd.count    = grc_pkg::DIV_CW'(grc_pkg::LH_W);
			end
			S_TS: begin
				div_cmd.start    = (lh_q != '0);
				div_cmd.dividend = grc_pkg::DVD_W'(grc_pkg::TS_NUM);
				div_cmd.divisor  = grc_pkg::DVS_W'(lh_q);
				div_cmd.count    = grc_pkg::DIV_CW'(grc_pkg::TS_CNT);
			end
			default: begin
				div_cmd = '0;
			end
		endcase
	end

	// camera registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 21'd1441792;
			pos_y_q   <= 21'd753664;
			dir_x_q   <= -18'sd65536;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 18'sd43254;
		end else if (cfg_we) begin
			case (cfg_index)
				grc_pkg::CFG_POS_X:   pos_x_q   <= cfg_data;
				grc_pkg::CFG_POS_Y:   pos_y_q   <= cfg_data;
				grc_pkg::CFG_DIR_X:   dir_x_q   <= signed'(cfg_data[17:0]);
				grc_pkg::CFG_DIR_Y:   dir_y_q   <= signed'(cfg_data[17:0]);
				grc_pkg::CFG_PLANE_X: plane_x_q <= signed'(cfg_data[17:0]);
				grc_pkg::CFG_PLANE_Y: plane_y_q <= signed'(cfg_data[17:0]);
				default: begin
				end
			endcase
		end
	end

	// cast sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cam_q   <= '0;
			rdx_q   <= '0;
			rdy_q   <= '0;
			ddx_q   <= '0;
			ddy_q   <= '0;
			sdx_q   <= '0;
			sdy_q   <= '0;
			xinf_q  <= 1'b0;
			yinf_q  <= 1'b0;
			mx_q    <= '0;
			my_q    <= '0;
			side_q  <= 1'b0;
			perp_q  <= '0;
			lh_q    <= '0;
			desc_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// columns off the screen are taken and dropped
					if (req_acc && req.req_type == grc_pkg::REQ_CAST
					    && int'(req.column) < grc_pkg::SCREEN_W) begin
						desc_q.out_column <= req.column;
						cam_q   <= cam_n;
						mx_q    <= 7'(pos_x_q[20:16]);
						my_q    <= 7'(pos_y_q[20:16]);
						xinf_q  <= 1'b0;
						yinf_q  <= 1'b0;
						side_q  <= 1'b0;
						desc_q.tex_num <= '0;
						state_q <= S_RAYX;
					end
				end
				S_RAYX: state_q <= S_RAYY;
				S_RAYY: begin
					rdx_q   <= RAY_W'(dir_x_q) + RAY_W'(mul_p >>> 16);
					state_q <= S_RAYW;
				end
				S_RAYW: begin
					rdy_q   <= RAY_W'(dir_y_q) + RAY_W'(mul_p >>> 16);
					state_q <= S_DIVX;
				end
				S_DIVX: begin
					if (rdx_q == 0) begin
						xinf_q  <= 1'b1;
						ddx_q   <= '0;
						state_q <= S_DIVY;
					end else begin
						state_q <= S_DIVXW;
					end
				end
				S_DIVXW: begin
					if (div_done) begin
						ddx_q   <= div_quo[DD_W-1:0];
						state_q <= S_MULX;
					end
				end
				S_MULX: state_q <= S_MULXW;
				S_MULXW: begin
					sdx_q   <= SD_W'(mul_p >>> 16);
					state_q <= S_DIVY;
				end
				S_DIVY: begin
					if (rdy_q == 0) begin
						yinf_q  <= 1'b1;
						ddy_q   <= '0;
						state_q <= S_WALK;
					end else begin
						state_q <= S_DIVYW;
					end
				end
				S_DIVYW: begin
					if (div_done) begin
						ddy_q   <= div_quo[DD_W-1:0];
						state_q <= S_MULY;
					end
				end
				S_MULY: state_q <= S_MULYW;
				S_MULYW: begin
					sdy_q   <= SD_W'(mul_p >>> 16);
					state_q <= S_WALK;
				end
				S_WALK: begin
					// step one cell; leaving the grid ends the walk as a hit
					if (xstep) begin
						sdx_q  <= sdx_q + SD_W'(ddx_q);
						side_q <= 1'b0;
					end else begin
						sdy_q  <= sdy_q + SD_W'(ddy_q);
						side_q <= 1'b1;
					end
					mx_q <= nmx;
					my_q <= nmy;
					if (n_out) begin
						desc_q.tex_num <= '0;
						state_q <= S_PERP;
					end else begin
						state_q <= S_WALKRD;
					end
				end
				S_WALKRD: begin
					if (map_rdata != '0) begin
						desc_q.tex_num <= 4'(map_rdata - 1'b1);
						state_q <= S_PERP;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_PERP: begin
					desc_q.hit_x <= mx_q[4:0];
					desc_q.hit_y <= my_q[4:0];
					desc_q.side  <= side_q;
					if (r_hit == 0) begin
						perp_q  <= grc_pkg::PERP_W'(grc_pkg::PERP_MAX);
						state_q <= S_LH;
					end else begin
						state_q <= S_PERPW;
					end
				end
				S_PERPW: begin
					if (div_done) begin
						perp_q <= (div_quo > grc_pkg::DVD_W'(grc_pkg::PERP_MAX))
						        ? grc_pkg::PERP_W'(grc_pkg::PERP_MAX)
						        : div_quo[grc_pkg::PERP_W-1:0];
						state_q <= S_LH;
					end
				end
				S_LH: begin
					desc_q.perp_dist <= perp_q;
					state_q <= S_LHW;
				end
				S_LHW: begin
					if (div_done) begin
						lh_q    <= div_quo[grc_pkg::LH_W-1:0];
						state_q <= S_TS;
					end
				end
				S_TS: begin
					desc_q.draw_start <= ds_n;
					desc_q.draw_end   <= de_n;
					if (lh_q == '0) begin
						// zero line height: texture step and start saturate
						desc_q.tex_step      <= 23'(grc_pkg::TEX_MAX);
						desc_q.tex_pos_start <= 23'(grc_pkg::TEX_MAX);
						state_q <= S_WMUL;
					end else begin
						state_q <= S_TSW;
					end
				end
				S_TSW: begin
					if (div_done) begin
						desc_q.tex_step <= (div_quo > grc_pkg::DVD_W'(grc_pkg::TEX_MAX))
						                 ? 23'(grc_pkg::TEX_MAX) : div_quo[22:0];
						state_q <= S_TPOS;
					end
				end
				S_TPOS: state_q <= S_TPOSW;
				S_TPOSW: begin
					desc_q.tex_pos_start <= (mul_p > $signed(grc_pkg::MUL_PW'(grc_pkg::TEX_MAX)))
					                      ? 23'(grc_pkg::TEX_MAX) : mul_p[22:0];
					state_q <= S_WMUL;
				end
				S_WMUL: state_q <= S_WALL;
				S_WALL: begin
					desc_q.tex_x <= 6'(mirror ? grc_pkg::TEX_W'(grc_pkg::TEX_SIZE - 1) - texx_n
					                          : texx_n);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!desc_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.done     (div_done),
		.quotient (div_quo)
	);

	grc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	grc_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (map_we),
		.waddr  (map_waddr),
		.wdata  (req.cell_value),
		.raddr  (map_raddr),
		.rdata  (map_rdata),
		.busy   (map_busy)
	);
endmodule
`default_nettype wire

FILE: dv/grid_ray_wall_caster_tb.sv
`timescale 1ns / 1ps
module grid_ray_wall_caster_tb;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	grc_pkg::req_t                  req = '0;
	logic                           desc_valid;
	logic                           desc_stall = 1'b0;
	grc_pkg::desc_t                 desc;
	logic                           cfg_we = 1'b0;
	logic [grc_pkg::CFG_IW-1:0]     cfg_index = grc_pkg::CFG_POS_X;
	logic [grc_pkg::CFG_W-1:0]      cfg_data = '0;

	grid_ray_wall_caster dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.desc_valid(desc_valid), .desc_stall(desc_stall), .desc(desc),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the block: map and camera registers
	logic [grc_pkg::CELL_W-1:0] shadow_map [0:grc_pkg::MAP_DEPTH-1] = '{default: '0};
	logic [grc_pkg::POS_W-1:0]  cam_pos_x = 21'd1441792, cam_pos_y = 21'd753664;
	logic [grc_pkg::VEC_W-1:0]  cam_dir_x = -18'sd65536, cam_dir_y = '0;
	logic [grc_pkg::VEC_W-1:0]  cam_plane_x = '0, cam_plane_y = 18'd43254;

	grc_pkg::req_t  pending_reqs [$];
	grc_pkg::desc_t expected_descs [$];
	int    sender_idle_pct = 11;
	int    receiver_stall_pct = 70;
	int    errors = 0;
	int    n_writes = 0, n_casts = 0, n_descs = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic longint floor16(input longint v);
		return v >>> 16;
	endfunction

	function automatic longint absval(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// per-axis walk setup: step direction, delta distance, first side distance
	function automatic void setup_axis(input longint p, input longint ray,
		output longint stp, output longint delta, output longint sdist);
		longint frac;
		frac = (ray < 0) ? (p & 'hFFFF) : (grc_pkg::ONE_Q16 - (p & 'hFFFF));
		stp = (ray < 0) ? -1 : 1;
		if (ray == 0) begin
			delta = 0;
			sdist = longint'(1) << 50;
		end else begin
			delta = (longint'(1) << 32) / absval(ray);
			sdist = (frac * delta) >>> 16;
		end
	endfunction

	// cast one column against the shadow map
	function automatic grc_pkg::desc_t cast_column(input logic [8:0] col);
		grc_pkg::desc_t d;
		longint cam, rdx, rdy, mx, my, stx, sty, ddx, ddy, sdx, sdy;
		longint num, r, perp, lh, ds, de, tstep, tpos, k, wall, texx, px, py;
		int     side, texnum;
		side = 0;
		texnum = 0;
		px = longint'(cam_pos_x);
		py = longint'(cam_pos_y);
		cam = ((2 * longint'(col)) << 16) / grc_pkg::SCREEN_W - grc_pkg::ONE_Q16;
		rdx = longint'($signed(cam_dir_x))
		    + floor16(longint'($signed(cam_plane_x)) * cam);
		rdy = longint'($signed(cam_dir_y))
		    + floor16(longint'($signed(cam_plane_y)) * cam);
		mx = px >>> 16;
		my = py >>> 16;
		setup_axis(px, rdx, stx, ddx, sdx);
		setup_axis(py, rdy, sty, ddy, sdy);
		// grid walk; ties step in y, leaving the grid is a hit
		forever begin
			if (sdx < sdy) begin
				sdx += ddx;
				mx += stx;
				side = 0;
			end else begin
				sdy += ddy;
				my += sty;
				side = 1;
			end
			if (mx < 0 || my < 0 || mx >= grc_pkg::MAP_DIM || my >= grc_pkg::MAP_DIM) begin
				texnum = 0;
				break;
			end
			if (shadow_map[mx * grc_pkg::MAP_DIM + my] != 0) begin
				texnum = shadow_map[mx * grc_pkg::MAP_DIM + my] - 1;
				break;
			end
		end
		if (side == 0) begin
			num = (mx + (stx < 0 ? 1 : 0)) * grc_pkg::ONE_Q16 - px;
			r = rdx;
		end else begin
			num = (my + (sty < 0 ? 1 : 0)) * grc_pkg::ONE_Q16 - py;
			r = rdy;
		end
		// zero ray on the hit side saturates the distance
		if (r == 0) perp = grc_pkg::PERP_MAX;
		else begin
			perp = (absval(num) << 16) / absval(r);
			if (perp > grc_pkg::PERP_MAX) perp = grc_pkg::PERP_MAX;
		end
		lh = (longint'(grc_pkg::SCREEN_H) << 16) / (perp != 0 ? perp : 1);
		ds = grc_pkg::SCREEN_H / 2 - lh / 2;
		if (ds < 0) ds = 0;
		de = lh / 2 + grc_pkg::SCREEN_H / 2;
		if (de >= grc_pkg::SCREEN_H) de = grc_pkg::SCREEN_H - 1;
		if (lh == 0) begin
			tstep = grc_pkg::TEX_MAX;
			tpos = grc_pkg::TEX_MAX;
		end else begin
			tstep = (longint'(grc_pkg::TEX_SIZE) << 16) / lh;
			if (tstep > grc_pkg::TEX_MAX) tstep = grc_pkg::TEX_MAX;
			k = ds - grc_pkg::SCREEN_H / 2 + lh / 2;
			if (k < 0) k = 0;
			tpos = k * tstep;
			if (tpos > grc_pkg::TEX_MAX) tpos = grc_pkg::TEX_MAX;
		end
		// texture column from the hit point on the other axis, mirrored on two faces
		wall = (side == 0) ? py + floor16(perp * rdy) : px + floor16(perp * rdx);
		texx = ((wall & 'hFFFF) * grc_pkg::TEX_SIZE) >>> 16;
		if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
			texx = grc_pkg::TEX_SIZE - texx - 1;
		d.out_column    = col;
		d.hit_x         = mx[4:0];
		d.hit_y         = my[4:0];
		d.side          = side[0];
		d.perp_dist     = perp[21:0];
		d.draw_start    = ds[8:0];
		d.draw_end      = de[8:0];
		d.tex_num       = texnum[3:0];
		d.tex_x         = texx[5:0];
		d.tex_step      = tstep[22:0];
		d.tex_pos_start = tpos[22:0];
		return d;
	endfunction

	// request driver: predicts on each accepted request, then offers the next
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				if (req.req_type == grc_pkg::REQ_WRITE) begin
					shadow_map[req.cell_x * grc_pkg::MAP_DIM + req.cell_y] <= req.cell_value;
					n_writes++;
				end else begin
					expected_descs.push_back(cast_column(req.column));
					n_casts++;
				end
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
			desc_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// shadow map write must precede a cast in the same cycle; handled by ordering:
	// a write is accepted alone since one request is worked at a time

	// descriptor monitor
	always @(posedge clk) begin
		grc_pkg::desc_t want;
		if (arst_n && desc_valid && !desc_stall) begin
			n_descs++;
			if (expected_descs.size() == 0) begin
				report_mismatch("unexpected descriptor column", desc.out_column, 0);
			end else begin
				want = expected_descs.pop_front();
				if (desc.out_column !== want.out_column)
					report_mismatch("out_column", desc.out_column, want.out_column);
				if (desc.hit_x !== want.hit_x)
					report_mismatch("hit_x", desc.hit_x, want.hit_x);
				if (desc.hit_y !== want.hit_y)
					report_mismatch("hit_y", desc.hit_y, want.hit_y);
				if (desc.side !== want.side)
					report_mismatch("side", desc.side, want.side);
				if (desc.perp_dist !== want.perp_dist)
					report_mismatch("perp_dist", desc.perp_dist, want.perp_dist);
				if (desc.draw_start !== want.draw_start)
					report_mismatch("draw_start", desc.draw_start, want.draw_start);
				if (desc.draw_end !== want.draw_end)
					report_mismatch("draw_end", desc.draw_end, want.draw_end);
				if (desc.tex_num !== want.tex_num)
					report_mismatch("tex_num", desc.tex_num, want.tex_num);
				if (desc.tex_x !== want.tex_x)
					report_mismatch("tex_x", desc.tex_x, want.tex_x);
				if (desc.tex_step !== want.tex_step)
					report_mismatch("tex_step", desc.tex_step, want.tex_step);
				if (desc.tex_pos_start !== want.tex_pos_start)
					report_mismatch("tex_pos_start", desc.tex_pos_start, want.tex_pos_start);
			end
		end
	end

	// register write through the config port and into the shadow camera
	task automatic write_reg(input logic [grc_pkg::CFG_IW-1:0] idx,
		input logic [grc_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			grc_pkg::CFG_POS_X:   cam_pos_x = val;
			grc_pkg::CFG_POS_Y:   cam_pos_y = val;
			grc_pkg::CFG_DIR_X:   cam_dir_x = val[grc_pkg::VEC_W-1:0];
			grc_pkg::CFG_DIR_Y:   cam_dir_y = val[grc_pkg::VEC_W-1:0];
			grc_pkg::CFG_PLANE_X: cam_plane_x = val[grc_pkg::VEC_W-1:0];
			grc_pkg::CFG_PLANE_Y: cam_plane_y = val[grc_pkg::VEC_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_camera(input logic [20:0] px, input logic [20:0] py,
		input logic [17:0] dx, input logic [17:0] dy,
		input logic [17:0] plx, input logic [17:0] ply);
		write_reg(grc_pkg::CFG_POS_X, px);
		write_reg(grc_pkg::CFG_POS_Y, py);
		write_reg(grc_pkg::CFG_DIR_X, {3'b0, dx});
		write_reg(grc_pkg::CFG_DIR_Y, {3'b0, dy});
		write_reg(grc_pkg::CFG_PLANE_X, {3'b0, plx});
		write_reg(grc_pkg::CFG_PLANE_Y, {3'b0, ply});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_write(input int x, input int y, input int v);
		grc_pkg::req_t r;
		r.req_type   = grc_pkg::REQ_WRITE;
		r.column     = 9'($urandom);
		r.cell_x     = x[4:0];
		r.cell_y     = y[4:0];
		r.cell_value = v[3:0];
		pending_reqs.push_back(r);
	endtask

	task automatic queue_cast(input int col);
		grc_pkg::req_t r;
		r.req_type   = grc_pkg::REQ_CAST;
		r.column     = col[8:0];
		r.cell_x     = 5'($urandom);
		r.cell_y     = 5'($urandom);
		r.cell_value = 4'($urandom);
		pending_reqs.push_back(r);
	endtask

	// wait for every request and descriptor, then let a ray finish its walk
	task automatic drain;
		while (pending_reqs.size() != 0 || req_valid || expected_descs.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// random requests: cell writes anywhere on the grid (about half clearing) mixed with casts
	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 35)
				queue_write($urandom_range(31), $urandom_range(31),
					($urandom_range(1) != 0) ? 0 : $urandom_range(15, 1));
			else
				queue_cast($urandom_range(511));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty map at the reset camera, rays leave the grid
		queue_cast(0);
		queue_cast(511);
		queue_cast(256);
		// corner cells and extreme wall values
		queue_write(0, 0, 15);
		queue_write(31, 31, 1);
		queue_write(31, 0, 8);
		queue_write(0, 31, 7);
		// wall straight ahead, then right beside the camera (distance near zero)
		queue_write(10, 11, 3);
		queue_cast(256);
		queue_write(21, 11, 5);
		queue_cast(256);
		queue_cast(1);
		queue_write(21, 11, 0);
		queue_cast(255);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			// idling: sender light/receiver heavy, then reversed, then none
			if (ph < 3) begin
				sender_idle_pct = 11;
				receiver_stall_pct = 70;
			end else if (ph < 6) begin
				sender_idle_pct = 70;
				receiver_stall_pct = 11;
			end else begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			case (ph)
				// zero x ray: the walk only steps in y
				0: set_camera(21'd0, 21'd0, 18'd0, 18'h1FFFF, 18'd0, 18'd0);
				// both rays zero, at the far corner
				1: set_camera(21'h1FFFFF, 21'h1FFFFF, 18'd0, 18'd0, 18'd0, 18'd0);
				// extreme vectors
				2: set_camera(21'd1048576, 21'd1081344, 18'h20000, 18'h1FFFF,
					18'h1FFFF, 18'h20000);
				default: set_camera(21'($urandom), 21'($urandom), 18'($urandom),
					18'($urandom), 18'($urandom), 18'($urandom));
			endcase
			queue_random(85);
			drain();
		end

		$display("covered %0d cell writes and %0d casts, %0d descriptors checked",
			n_writes, n_casts, n_descs);
		$display("camera settings: reset, zero-ray, corner, extreme and random vectors");
		if (errors == 0)
			$display("grid_ray_wall_caster_tb passed");
		else
			$display("grid_ray_wall_caster_tb failed");
		$finish;
	end

	// watchdog
	initial begin
		#60ms;
		$display("grid_ray_wall_caster_tb failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/grc_pkg.sv
rtl/core/grc_div.sv
rtl/core/grc_mul.sv
rtl/core/grc_map.sv
rtl/core/grid_ray_wall_caster.sv
dv/grid_ray_wall_caster_tb.sv
